@@ src/md5_pkg.sv @@
`default_nettype none

package md5_pkg;

	localparam logic [31:0] InitA = 32'h67452301;
	localparam logic [31:0] InitB = 32'hefcdab89;
	localparam logic [31:0] InitC = 32'h98badcfe;
	localparam logic [31:0] InitD = 32'h10325476;

	localparam logic [31:0] PadByte = 32'h0000_0080;

	// Additive constant of one round.
	function automatic logic [31:0] sine_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Left rotate amount of one round.
	function automatic logic [4:0] rot_amt(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'b00_00: s = 5'd7;
			4'b00_01: s = 5'd12;
			4'b00_10: s = 5'd17;
			4'b00_11: s = 5'd22;
			4'b01_00: s = 5'd5;
			4'b01_01: s = 5'd9;
			4'b01_10: s = 5'd14;
			4'b01_11: s = 5'd20;
			4'b10_00: s = 5'd4;
			4'b10_01: s = 5'd11;
			4'b10_10: s = 5'd16;
			4'b10_11: s = 5'd23;
			4'b11_00: s = 5'd6;
			4'b11_01: s = 5'd10;
			4'b11_10: s = 5'd15;
			4'b11_11: s = 5'd21;
			default:  s = 5'd0;
		endcase
		return s;
	endfunction

	// Buffer word that one round reads.
	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [3:0] rl;
		logic [3:0] g;
		rl = r[3:0];
		case (r[5:4])
			2'd0:    g = rl;
			2'd1:    g = rl + (rl << 2) + 4'd1;
			2'd2:    g = rl + (rl << 1) + 4'd5;
			default: g = (rl << 3) - rl;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] sh);
		logic [63:0] dbl;
		dbl = {x, x} << sh;
		return dbl[63:32];
	endfunction

	function automatic logic [31:0] bswap32(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

`default_nettype wire

@@ src/md5_hash.sv @@
// Streaming MD5 hasher. Message words enter one at a time on the input
// channel (first byte in bits 7:0, valid_bytes below four only with is_last),
// and after the last word two 64-bit digest words leave on the output channel,
// digest bytes 0-7 first. A word that does not fill the block buffer leaves
// the input free for the next word. The sixteenth word of a block starts the
// compression, which runs one round per cycle on a single shared round unit:
// a setup step, 64 rounds and a fold into the chaining words, during which
// the input is stalled. On the last word the padding and length words are
// written into the buffer one per cycle, with one or two compressions, then
// the digest is offered. The round loop, which stalls the input, limits how
// fast message words can enter.
`default_nettype none

module md5_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] message_word,
	input  wire logic [2:0]  valid_bytes,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      digest_part,
	output logic             part_last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_PREP,
		S_ROUND,
		S_FOLD,
		S_OUT0,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		P_FIRST,
		P_ZERO,
		P_HI
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic [31:0] h_q [4];
	logic [31:0] blk_q [16];
	logic [3:0]  pos_q;
	logic [63:0] bits_q;
	logic [31:0] pend_q;
	logic        pad_q;
	logic        fin_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] km_q;
	logic        out_valid_q;
	logic [63:0] digest_q;
	logic        part_last_q;

	logic        in_acc;
	logic        out_acc;
	logic [2:0]  nb;
	logic [31:0] pad_word;
	logic        push_en;
	logic [31:0] push_data;
	logic [31:0] f_val;
	logic [31:0] sum_val;
	logic [31:0] new_b;
	logic [5:0]  rnd_nxt;
	logic [31:0] km_nxt;

	assign in_stall    = (state_q != S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign digest_part = digest_q;
	assign part_last   = part_last_q;
	assign out_acc     = out_valid_q && !out_stall;

	// Count of message bytes this word brings.
	always_comb begin
		if (!is_last || valid_bytes > 3'd4) begin
			nb = 3'd4;
		end else begin
			nb = valid_bytes;
		end
	end

	// Short last word: clear unused bytes, place the pad byte.
	always_comb begin
		case (nb)
			3'd0:    pad_word = md5_pkg::PadByte;
			3'd1:    pad_word = {16'h0, md5_pkg::PadByte[7:0], message_word[7:0]};
			3'd2:    pad_word = {8'h0, md5_pkg::PadByte[7:0], message_word[15:0]};
			3'd3:    pad_word = {md5_pkg::PadByte[7:0], message_word[23:0]};
			default: pad_word = md5_pkg::PadByte;
		endcase
	end

	always_comb begin
		push_en   = 1'b0;
		push_data = message_word;
		case (state_q)
			S_IDLE: begin
				push_en   = in_acc && nb == 3'd4;
				push_data = message_word;
			end
			S_PAD: begin
				push_en = 1'b1;
				case (phase_q)
					P_FIRST: push_data = pend_q;
					P_ZERO:  push_data = (pos_q == 4'd14) ? bits_q[31:0] : 32'h0;
					P_HI:    push_data = bits_q[63:32];
					default: push_data = 32'h0;
				endcase
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			blk_q[pos_q] <= push_data;
		end
	end

	// Shared round unit.
	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		sum_val = a_q + f_val + km_q;
		new_b   = b_q + md5_pkg::rotl32(sum_val, md5_pkg::rot_amt(rnd_q));
		rnd_nxt = rnd_q + 6'd1;
		km_nxt  = md5_pkg::sine_k(rnd_nxt) + blk_q[md5_pkg::msg_index(rnd_nxt)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= P_FIRST;
			h_q[0]      <= md5_pkg::InitA;
			h_q[1]      <= md5_pkg::InitB;
			h_q[2]      <= md5_pkg::InitC;
			h_q[3]      <= md5_pkg::InitD;
			pos_q       <= 4'd0;
			bits_q      <= 64'd0;
			pad_q       <= 1'b0;
			fin_q       <= 1'b0;
			rnd_q       <= 6'd0;
			out_valid_q <= 1'b0;
			part_last_q <= 1'b0;
		end else begin
			if (push_en) begin
				pos_q <= pos_q + 4'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						bits_q <= bits_q + {58'd0, nb, 3'd0};
						if (is_last) begin
							pad_q   <= 1'b1;
							phase_q <= P_FIRST;
							pend_q  <= pad_word;
						end
						if (push_en && pos_q == 4'd15) begin
							state_q <= S_PREP;
						end else if (is_last) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					case (phase_q)
						P_FIRST: phase_q <= P_ZERO;
						P_ZERO: begin
							if (pos_q == 4'd14) begin
								phase_q <= P_HI;
							end
						end
						default: fin_q <= 1'b1;
					endcase
					if (pos_q == 4'd15) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					a_q     <= h_q[0];
					b_q     <= h_q[1];
					c_q     <= h_q[2];
					d_q     <= h_q[3];
					km_q    <= md5_pkg::sine_k(6'd0) + blk_q[md5_pkg::msg_index(6'd0)];
					rnd_q   <= 6'd0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					a_q   <= d_q;
					b_q   <= new_b;
					c_q   <= b_q;
					d_q   <= c_q;
					km_q  <= km_nxt;
					rnd_q <= rnd_nxt;
					if (rnd_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					if (fin_q) begin
						state_q <= S_OUT0;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT0: begin
					out_valid_q <= 1'b1;
					part_last_q <= 1'b0;
					digest_q    <= {md5_pkg::bswap32(h_q[0]), md5_pkg::bswap32(h_q[1])};
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (!part_last_q) begin
							part_last_q <= 1'b1;
							digest_q    <= {md5_pkg::bswap32(h_q[2]),
								md5_pkg::bswap32(h_q[3])};
						end else begin
							// Digest gone: start a new message.
							out_valid_q <= 1'b0;
							part_last_q <= 1'b0;
							h_q[0]      <= md5_pkg::InitA;
							h_q[1]      <= md5_pkg::InitB;
							h_q[2]      <= md5_pkg::InitC;
							h_q[3]      <= md5_pkg::InitD;
							pos_q       <= 4'd0;
							bits_q      <= 64'd0;
							pad_q       <= 1'b0;
							fin_q       <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while digest word pending");

	a_second_part: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !part_last) |=> (out_valid && part_last))
		else $error("second digest word missing");

	a_new_message: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && part_last) |=>
		(pos_q == 4'd0 && bits_q == 64'd0 && !out_valid))
		else $error("message state not cleared after digest");

	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ROUND) |-> (rnd_q == 6'd0))
		else $error("round counter off outside compression");

endmodule

`default_nettype wire

@@ dv/md5_hash_checker.sv @@
`default_nettype none

module md5_hash_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] message_word,
	input  wire logic [2:0]  valid_bytes,
	input  wire logic        is_last,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [63:0] digest_part,
	input  wire logic        part_last,
	output int               err_count,
	output int               pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] CHAIN_A = 32'h67452301;
	localparam logic [31:0] CHAIN_B = 32'hefcdab89;
	localparam logic [31:0] CHAIN_C = 32'h98badcfe;
	localparam logic [31:0] CHAIN_D = 32'h10325476;
	localparam logic [31:0] PAD_MARK = 32'h0000_0080;
	localparam int BLOCK_WORDS = 16;
	localparam int LEN_POS = 14;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROUND_ROT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	typedef struct {
		logic [63:0] value;
		logic        tail;
	} digest_t;

	logic [31:0] chain [4];
	logic [31:0] blk [16];
	int          blk_pos;
	logic [63:0] msg_bits;
	digest_t     digest_q [$];

	function automatic logic [31:0] byte_rev(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic void restart_chain();
		chain[0] = CHAIN_A;
		chain[1] = CHAIN_B;
		chain[2] = CHAIN_C;
		chain[3] = CHAIN_D;
		blk_pos = 0;
		msg_bits = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] a, b, c, d, f, sum, hold;
		int          g, sh;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			sh = ROUND_ROT[(r / 16) * 4 + r % 4];
			sum = a + f + ROUND_K[r] + blk[g];
			hold = d;
			d = c;
			c = b;
			b = b + ((sum << sh) | (sum >> (32 - sh)));
			a = hold;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endfunction

	function automatic void append_word(input logic [31:0] w);
		blk[blk_pos] = w;
		blk_pos++;
		if (blk_pos == BLOCK_WORDS) begin
			compress_block();
			blk_pos = 0;
		end
	endfunction

	function automatic void hash_word(input logic [31:0] w, input logic [2:0] nb,
			input logic last);
		int          n;
		logic [31:0] keep, pad;
		digest_t     dg;
		n = (!last || nb > 3'd4) ? 4 : int'(nb);
		msg_bits += 64'(8 * n);
		if (!last) begin
			append_word(w);
			return;
		end
		if (n == 4) begin
			append_word(w);
			pad = PAD_MARK;
		end else begin
			keep = (n == 0) ? 32'h0 : (32'hffff_ffff >> (32 - 8 * n));
			pad = (w & keep) | (PAD_MARK << (8 * n));
		end
		append_word(pad);
		// no room for the length: flush this block and pad a fresh one
		if (blk_pos > LEN_POS) begin
			while (blk_pos != 0)
				append_word(32'h0);
		end
		while (blk_pos < LEN_POS)
			append_word(32'h0);
		append_word(msg_bits[31:0]);
		append_word(msg_bits[63:32]);
		dg.value = {byte_rev(chain[0]), byte_rev(chain[1])};
		dg.tail = 1'b0;
		digest_q = {digest_q, dg};
		dg.value = {byte_rev(chain[2]), byte_rev(chain[3])};
		dg.tail = 1'b1;
		digest_q = {digest_q, dg};
		restart_chain();
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			restart_chain();
			digest_q.delete();
			err_count = 0;
		end else begin
			if (in_valid && !in_stall)
				hash_word(message_word, valid_bytes, is_last);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$error("digest word with nothing expected: %h", digest_part);
					err_count++;
				end else begin
					if (digest_part !== digest_q[0].value) begin
						$error("digest_part: expected %h, got %h", digest_q[0].value,
							digest_part);
						err_count++;
					end
					if (part_last !== digest_q[0].tail) begin
						$error("part_last: expected %b, got %b", digest_q[0].tail, part_last);
						err_count++;
					end
					void'(digest_q.pop_front());
				end
			end
		end
		pending = digest_q.size();
	end

endmodule

`default_nettype wire

@@ dv/md5_hash_tb.sv @@
`default_nettype none

module md5_hash_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_TARGET = 1050;
	localparam int DRAIN_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] message_word = '0;
	logic [2:0]  valid_bytes = '0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] digest_part;
	logic        part_last;
	int          err_count;
	int          pending;

	int          words_sent = 0;
	logic        burst = 1'b0;
	int          stall_left = 0;
	int          stall_roll;

	md5_hash dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_word (message_word),
		.valid_bytes  (valid_bytes),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_part  (digest_part),
		.part_last    (part_last)
	);

	md5_hash_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_word (message_word),
		.valid_bytes  (valid_bytes),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_part  (digest_part),
		.part_last    (part_last),
		.err_count    (err_count),
		.pending      (pending)
	);

	always #1 clk = ~clk;

	// Digest side backpressure: runs of stall and of free flow, mostly short.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end else begin
			stall_roll = $urandom_range(0, 9);
			if (stall_roll < 4) begin
				out_stall <= 1'b1;
				stall_left = (stall_roll == 0) ? $urandom_range(10, 60)
					: $urandom_range(0, 3);
			end else begin
				stall_left = $urandom_range(0, 5);
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		message_word <= w;
		valid_bytes <= nb;
		is_last <= last;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_message(input int len);
		logic [2:0] nb;
		burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len - 1; i++) begin
			// count is ignored before the last word
			nb = ($urandom_range(0, 9) < 7) ? 3'd4 : 3'($urandom_range(0, 7));
			send_word(rand_word(), nb, 1'b0);
		end
		nb = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
			: 3'($urandom_range(5, 7));
		send_word(rand_word(), nb, 1'b1);
	endtask

	initial begin
		int roll;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty message
		send_word(32'h5a5a_a5a5, 3'd0, 1'b1);
		// one-word messages of every length
		send_word(32'hffff_ffff, 3'd1, 1'b1);
		send_word(32'h0000_0000, 3'd2, 1'b1);
		send_word(32'hffff_ffff, 3'd3, 1'b1);
		send_word(32'h0000_0000, 3'd4, 1'b1);
		// counts above four on the last word
		send_word(32'hdead_beef, 3'd5, 1'b1);
		send_word(32'h0123_4567, 3'd7, 1'b1);
		// short count before the end is taken as full
		send_word(32'h89ab_cdef, 3'd0, 1'b0);
		send_word(32'h7654_3210, 3'd3, 1'b1);
		// pad spills past the length slot: two final blocks
		for (int i = 0; i < 14; i++)
			send_word(rand_word(), 3'd4, 1'b0);
		send_word(32'hffff_ffff, 3'd4, 1'b1);

		while (words_sent < WORD_TARGET) begin
			roll = $urandom_range(0, 9);
			if (roll < 6)
				send_message($urandom_range(1, 20));
			else if (roll < 9)
				send_message($urandom_range(21, 40));
			else
				send_message($urandom_range(41, 80));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
